// ----- hw/rtl/rcvs_pkg.sv -----
package rcvs_pkg;

  localparam int unsigned DIST_WIDTH_DEF = 32;
  localparam int unsigned OUT_WIDTH_DEF  = 32;
  localparam int unsigned TRIG_TERMS     = 18;
  localparam int unsigned EXP_TERMS      = 13;
  localparam int unsigned DIV_BITS       = 30;
  localparam int unsigned CFG_DW         = 32;
  localparam int unsigned CFG_IW         = 3;

  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [30:0] HALF_Q30 = 31'h2000_0000;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;

  typedef enum logic [1:0] {
    MODE_COS       = 2'd0,
    MODE_TANH      = 2'd1,
    MODE_TANH_NORM = 2'd2,
    MODE_OFF       = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE          = 3'd0,
    REG_CUTOFF_RADIUS = 3'd1,
    REG_INV_RADIUS    = 3'd2,
    REG_INNER_RADIUS  = 3'd3,
    REG_INV_WIDTH     = 3'd4
  } reg_e;

  typedef struct packed {
    logic beyond;
    logic below_inner;
    logic h_neg;
  } side_t;

  typedef struct packed {
    logic [30:0] fc;
    logic [32:0] mag;
  } hold_t;

  function automatic logic [63:0] const_quot(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] calc_norm_const();
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] t1;
    logic [63:0] c;
    logic [63:0] c2;
    term = 64'(ONE_Q30);
    e    = 64'd0;
    for (int n = 0; n < EXP_TERMS; n++) begin
      if (n > 0) term = const_quot((term * 64'd268435456) >> 30, 64'(n));
      e = e + term;
    end
    for (int n = 0; n < 3; n++) e = (e * e) >> 30;
    if (e < 64'(ONE_Q30)) e = 64'(ONE_Q30);
    t1 = const_quot((e - 64'(ONE_Q30)) << 30, e + 64'(ONE_Q30));
    if (t1 == 64'd0) t1 = 64'd1;
    c  = const_quot(64'd1 << 60, t1);
    c2 = (c * c) >> 30;
    return (c2 * c) >> 30;
  endfunction

  localparam logic [31:0] KNORM_Q30 = 32'(calc_norm_const());

endpackage

// ----- hw/rtl/rcvs_series_cell.sv -----
module rcvs_series_cell #(
  parameter int unsigned N = 1
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                trig_i,
  input  logic [31:0]         term_i,
  input  logic [31:0]         xa_i,
  input  logic signed [33:0]  acc0_i,
  input  logic signed [33:0]  acc1_i,
  input  rcvs_pkg::side_t     side_i,
  output logic [31:0]         term_o,
  output logic [31:0]         xa_o,
  output logic signed [33:0]  acc0_o,
  output logic signed [33:0]  acc1_o,
  output rcvs_pkg::side_t     side_o
);
  import rcvs_pkg::*;

  localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / N);
  localparam logic [4:0]  NC      = 5'(N);
  localparam bit          ACC_COS = (N % 2) == 0;
  localparam bit          NEG     = ((N / 2) % 2) == 1;
  localparam bit          EXP_ON  = N < EXP_TERMS;

  logic [31:0]        a_p_q, a_xa_q;
  logic signed [33:0] a_acc0_q, a_acc1_q;
  side_t              a_side_q;
  logic [31:0]        b_p_q, b_q0_q, b_xa_q;
  logic signed [33:0] b_acc0_q, b_acc1_q;
  side_t              b_side_q;
  logic [31:0]        c_term_q, c_xa_q;
  logic signed [33:0] c_acc0_q, c_acc1_q;
  side_t              c_side_q;

  logic [63:0]        prod_a;
  logic [64:0]        prod_b;
  logic [36:0]        qn, rem;
  logic               ge;
  logic [31:0]        q;
  logic signed [33:0] qs, acc0_d, acc1_d;

  assign prod_a = {32'b0, term_i} * {32'b0, xa_i};
  assign prod_b = {33'b0, a_p_q} * {32'b0, RECIP};
  assign qn     = {5'b0, b_q0_q} * {32'b0, NC};
  assign rem    = {5'b0, b_p_q} - qn;
  assign ge     = rem >= 37'(NC);
  assign q      = b_q0_q + 32'(ge);
  assign qs     = $signed({2'b0, q});

  always_comb begin
    acc0_d = b_acc0_q;
    acc1_d = b_acc1_q;
    if (trig_i) begin
      if (ACC_COS) begin
        acc0_d = NEG ? b_acc0_q - qs : b_acc0_q + qs;
      end else begin
        acc1_d = NEG ? b_acc1_q - qs : b_acc1_q + qs;
      end
    end else if (EXP_ON) begin
      acc0_d = b_acc0_q + qs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_p_q    <= prod_a[61:30];
      a_xa_q   <= xa_i;
      a_acc0_q <= acc0_i;
      a_acc1_q <= acc1_i;
      a_side_q <= side_i;
      b_p_q    <= a_p_q;
      b_q0_q   <= prod_b[63:32];
      b_xa_q   <= a_xa_q;
      b_acc0_q <= a_acc0_q;
      b_acc1_q <= a_acc1_q;
      b_side_q <= a_side_q;
      c_term_q <= q;
      c_xa_q   <= b_xa_q;
      c_acc0_q <= acc0_d;
      c_acc1_q <= acc1_d;
      c_side_q <= b_side_q;
    end
  end

  assign term_o = c_term_q;
  assign xa_o   = c_xa_q;
  assign acc0_o = c_acc0_q;
  assign acc1_o = c_acc1_q;
  assign side_o = c_side_q;

endmodule

// ----- hw/rtl/rcvs_div_cell.sv -----
module rcvs_div_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [33:0]                   rem_i,
  input  logic [33:0]                   den_i,
  input  logic [rcvs_pkg::DIV_BITS-1:0] quo_i,
  input  rcvs_pkg::hold_t               hold_i,
  input  rcvs_pkg::side_t               side_i,
  output logic [33:0]                   rem_o,
  output logic [33:0]                   den_o,
  output logic [rcvs_pkg::DIV_BITS-1:0] quo_o,
  output rcvs_pkg::hold_t               hold_o,
  output rcvs_pkg::side_t               side_o
);
  import rcvs_pkg::*;

  logic [34:0]         rs, diff;
  logic                ge;
  logic [33:0]         rem_q, den_q;
  logic [DIV_BITS-1:0] quo_q;
  hold_t               hold_q;
  side_t               side_q;

  assign rs   = {rem_i, 1'b0};
  assign diff = rs - {1'b0, den_i};
  assign ge   = rs >= {1'b0, den_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= ge ? diff[33:0] : rs[33:0];
      den_q  <= den_i;
      quo_q  <= {quo_i[DIV_BITS-2:0], ge};
      hold_q <= hold_i;
      side_q <= side_i;
    end
  end

  assign rem_o  = rem_q;
  assign den_o  = den_q;
  assign quo_o  = quo_q;
  assign hold_o = hold_q;
  assign side_o = side_q;

endmodule

// ----- hw/rtl/radial_cutoff_value_and_slope.sv -----
// channel | direction | handshake                 | payload
// --------+-----------+---------------------------+-----------------------------------------
// in      | input     | in_valid_i / in_stall_o   | distance_i
// out     | output    | out_valid_o / out_stall_i | cut_value_o, cut_slope_o, beyond_cutoff_o
// cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One distance per cycle while in_stall_o is low: a 17-cell Taylor series chain
// (registers a, b and c in each cell) and a 30-cell restoring divider set the depth.
// Reset clears the valid bits of pipe, skid and output and the configuration registers.
// The pipeline advances while the skid stage is empty; a stalled result parks in
// the output register and one more in the skid stage, then in_stall_o rises.
module radial_cutoff_value_and_slope #(
  parameter int unsigned DIST_WIDTH = rcvs_pkg::DIST_WIDTH_DEF,
  parameter int unsigned OUT_WIDTH  = rcvs_pkg::OUT_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [DIST_WIDTH-1:0]       distance_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [OUT_WIDTH-1:0] cut_value_o,
  output logic signed [OUT_WIDTH-1:0] cut_slope_o,
  output logic                        beyond_cutoff_o,
  input  logic                        cfg_we_i,
  input  logic [rcvs_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [rcvs_pkg::CFG_DW-1:0] cfg_data_i
);
  import rcvs_pkg::*;

  localparam int unsigned CELLS = TRIG_TERMS - 1;
  localparam int unsigned LAT   = 4 + 3 * CELLS + 4 + DIV_BITS + 4;
  localparam int unsigned CMP_W = DIST_WIDTH > 32 ? DIST_WIDTH : 32;

  typedef struct packed {
    logic [31:0] fc;
    logic [31:0] df;
    logic        beyond;
  } res_t;

  mode_e       mode_q;
  logic [31:0] rc_q, rcinv_q, rin_q, iw_q;
  logic        cos_mode;

  logic [LAT-1:0] vld_q;
  logic           en;
  logic           out_vld_q, skid_vld_q;
  res_t           out_q, skid_q, tail_res;
  logic           take;

  assign cos_mode   = mode_q == MODE_COS;
  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;
  assign take       = out_vld_q && !out_stall_i;

  // front stages
  logic [CMP_W-1:0] d_ext;
  logic             bey;
  logic [31:0]      s1_r_q;
  side_t            s1_side_q;
  logic [32:0]      diff2;
  logic [31:0]      opa2, opb2;
  logic [63:0]      prod2;
  logic [63:0]      s2_prod_q;
  side_t            s2_side_q;
  logic [49:0]      xw;
  logic [30:0]      xs, u3;
  logic             hneg;
  logic [29:0]      ah;
  logic [29:0]      s3_arg_q;
  side_t            s3_side_q;
  logic [63:0]      prod4;
  logic [31:0]      s4_xa_q;
  side_t            s4_side_q;

  assign d_ext = CMP_W'(distance_i);
  assign bey   = d_ext > CMP_W'(rc_q);
  assign diff2 = {1'b0, s1_r_q} - {1'b0, rin_q};
  assign opa2  = cos_mode ? diff2[31:0] : s1_r_q;
  assign opb2  = cos_mode ? iw_q : rcinv_q;
  assign prod2 = {32'b0, opa2} * {32'b0, opb2};
  assign xw    = s2_prod_q[63:14];
  assign xs    = (xw > 50'(ONE_Q30)) ? ONE_Q30 : xw[30:0];
  assign hneg  = xs > HALF_Q30;
  assign ah    = hneg ? 30'(xs - HALF_Q30) : 30'(HALF_Q30 - xs);
  assign u3    = (xw >= 50'(ONE_Q30)) ? 31'd0 : ONE_Q30 - xw[30:0];
  assign prod4 = {34'b0, s3_arg_q} * {32'b0, PI_Q30};

  // series chain
  logic [31:0]        term_w [TRIG_TERMS];
  logic [31:0]        xa_w   [TRIG_TERMS];
  logic signed [33:0] acc0_w [TRIG_TERMS];
  logic signed [33:0] acc1_w [TRIG_TERMS];
  side_t              sside_w[TRIG_TERMS];

  assign term_w[0]  = 32'(ONE_Q30);
  assign xa_w[0]    = s4_xa_q;
  assign acc0_w[0]  = $signed(34'(ONE_Q30));
  assign acc1_w[0]  = '0;
  assign sside_w[0] = s4_side_q;

  for (genvar n = 1; n < TRIG_TERMS; n++) begin : g_series
    rcvs_series_cell #(.N(n)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .trig_i (cos_mode),
      .term_i (term_w[n-1]),
      .xa_i   (xa_w[n-1]),
      .acc0_i (acc0_w[n-1]),
      .acc1_i (acc1_w[n-1]),
      .side_i (sside_w[n-1]),
      .term_o (term_w[n]),
      .xa_o   (xa_w[n]),
      .acc0_o (acc0_w[n]),
      .acc1_o (acc1_w[n]),
      .side_o (sside_w[n])
    );
  end

  // post stages
  logic signed [33:0] acc0_e, acc1_e;
  logic [30:0]        sa, ca, fcc;
  logic [31:0]        fsum;
  logic [31:0]        ma1, mb1;
  logic [63:0]        prod_p1, prod_p2, prod_p3;
  logic [31:0]        p1_pa_q;
  logic [30:0]        p1_fc_q;
  side_t              p1_side_q;
  logic [32:0]        p2_pa_q;
  logic [30:0]        p2_fc_q;
  side_t              p2_side_q;
  logic [32:0]        p3_pa_q;
  logic [30:0]        p3_fc_q;
  side_t              p3_side_q;
  logic [32:0]        e4;
  logic [33:0]        dv_rem_q, dv_den_q;
  hold_t              dv_hold_q;
  side_t              dv_side_q;

  assign acc0_e  = acc0_w[TRIG_TERMS-1];
  assign acc1_e  = acc1_w[TRIG_TERMS-1];
  assign sa      = acc1_e[33] ? 31'd0 :
                   (acc1_e > $signed(34'(ONE_Q30))) ? ONE_Q30 : acc1_e[30:0];
  assign ca      = acc0_e[33] ? 31'd0 :
                   (acc0_e > $signed(34'(ONE_Q30))) ? ONE_Q30 : acc0_e[30:0];
  assign fsum    = sside_w[TRIG_TERMS-1].h_neg ? 32'(ONE_Q30) - 32'(sa)
                                               : 32'(ONE_Q30) + 32'(sa);
  assign fcc     = sside_w[TRIG_TERMS-1].below_inner ? ONE_Q30 : fsum[31:1];
  assign ma1     = cos_mode ? {1'b0, ca} : acc0_e[31:0];
  assign mb1     = cos_mode ? PI_Q30 : acc0_e[31:0];
  assign prod_p1 = {32'b0, ma1} * {32'b0, mb1};
  assign prod_p2 = {32'b0, p1_pa_q} * {32'b0, (cos_mode ? iw_q : p1_pa_q)};
  assign prod_p3 = {32'b0, p2_pa_q[31:0]} * {32'b0, p2_pa_q[31:0]};
  assign e4      = (p3_pa_q < 33'(ONE_Q30)) ? 33'(ONE_Q30) : p3_pa_q;

  // divider chain
  logic [33:0]         rem_w [DIV_BITS+1];
  logic [33:0]         den_w [DIV_BITS+1];
  logic [DIV_BITS-1:0] quo_w [DIV_BITS+1];
  hold_t               hold_w[DIV_BITS+1];
  side_t               dside_w[DIV_BITS+1];

  assign rem_w[0]   = dv_rem_q;
  assign den_w[0]   = dv_den_q;
  assign quo_w[0]   = '0;
  assign hold_w[0]  = dv_hold_q;
  assign dside_w[0] = dv_side_q;

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    rcvs_div_cell u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rem_w[i]),
      .den_i  (den_w[i]),
      .quo_i  (quo_w[i]),
      .hold_i (hold_w[i]),
      .side_i (dside_w[i]),
      .rem_o  (rem_w[i+1]),
      .den_o  (den_w[i+1]),
      .quo_o  (quo_w[i+1]),
      .hold_o (hold_w[i+1]),
      .side_o (dside_w[i+1])
    );
  end

  // tanh tail
  logic [29:0] tq;
  logic [59:0] prod_q1, prod_q2a;
  logic [60:0] prod_q2b;
  logic [29:0] q1_p_q, q1_t_q;
  hold_t       q1_hold_q;
  side_t       q1_side_q;
  logic [30:0] one_m_p;
  logic [29:0] q2_qv_q;
  logic [28:0] q2_mv_q;
  hold_t       q2_hold_q;
  side_t       q2_side_q;
  logic [31:0] kq;
  logic [30:0] m3;
  logic [63:0] prod_q3a, prod_q3b, prod_q4;
  logic [31:0] q3_fc_q, q3_mk_q;
  hold_t       q3_hold_q;
  side_t       q3_side_q;
  logic [31:0] q4_fc_q;
  logic [33:0] q4_mag_q;
  hold_t       q4_hold_q;
  side_t       q4_side_q;

  assign tq       = quo_w[DIV_BITS];
  assign prod_q1  = {30'b0, tq} * {30'b0, tq};
  assign prod_q2a = {30'b0, q1_p_q} * {30'b0, q1_t_q};
  assign one_m_p  = ONE_Q30 - {1'b0, q1_p_q};
  assign prod_q2b = {31'b0, q1_p_q} * {30'b0, one_m_p};
  assign kq       = (mode_q == MODE_TANH_NORM) ? KNORM_Q30 : 32'(ONE_Q30);
  assign m3       = {1'b0, q2_mv_q, 1'b0} + {2'b0, q2_mv_q};
  assign prod_q3a = {34'b0, q2_qv_q} * {32'b0, kq};
  assign prod_q3b = {33'b0, m3} * {32'b0, kq};
  assign prod_q4  = {32'b0, q3_mk_q} * {32'b0, rcinv_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_r_q    <= bey ? rc_q : d_ext[31:0];
      s1_side_q <= '{beyond: bey, below_inner: 1'b0, h_neg: 1'b0};
      s2_prod_q <= prod2;
      s2_side_q <= '{beyond: s1_side_q.beyond, below_inner: diff2[32], h_neg: 1'b0};
      s3_arg_q  <= cos_mode ? ah : {1'b0, u3[30:2]};
      s3_side_q <= '{beyond: s2_side_q.beyond, below_inner: s2_side_q.below_inner,
                     h_neg: hneg};
      s4_xa_q   <= cos_mode ? prod4[61:30] : {2'b0, s3_arg_q};
      s4_side_q <= s3_side_q;
      p1_pa_q   <= prod_p1[61:30];
      p1_fc_q   <= fcc;
      p1_side_q <= sside_w[TRIG_TERMS-1];
      p2_pa_q   <= cos_mode ? prod_p2[63:31] : prod_p2[62:30];
      p2_fc_q   <= p1_fc_q;
      p2_side_q <= p1_side_q;
      p3_pa_q   <= cos_mode ? p2_pa_q : prod_p3[62:30];
      p3_fc_q   <= p2_fc_q;
      p3_side_q <= p2_side_q;
      dv_rem_q  <= 34'(e4) - 34'(ONE_Q30);
      dv_den_q  <= 34'(e4) + 34'(ONE_Q30);
      dv_hold_q <= '{fc: p3_fc_q, mag: (p3_side_q.below_inner ? 33'd0 : p3_pa_q)};
      dv_side_q <= p3_side_q;
      q1_p_q    <= prod_q1[59:30];
      q1_t_q    <= tq;
      q1_hold_q <= hold_w[DIV_BITS];
      q1_side_q <= dside_w[DIV_BITS];
      q2_qv_q   <= prod_q2a[59:30];
      q2_mv_q   <= prod_q2b[58:30];
      q2_hold_q <= q1_hold_q;
      q2_side_q <= q1_side_q;
      q3_fc_q   <= prod_q3a[61:30];
      q3_mk_q   <= prod_q3b[61:30];
      q3_hold_q <= q2_hold_q;
      q3_side_q <= q2_side_q;
      q4_fc_q   <= q3_fc_q;
      q4_mag_q  <= prod_q4[63:30];
      q4_hold_q <= q3_hold_q;
      q4_side_q <= q3_side_q;
    end
  end

  // result select and saturation
  logic [31:0] fcr, fcs;
  logic [33:0] magr, mags, magn;

  always_comb begin
    case (mode_q)
      MODE_COS: begin
        fcr  = {1'b0, q4_hold_q.fc};
        magr = {1'b0, q4_hold_q.mag};
      end
      MODE_TANH, MODE_TANH_NORM: begin
        fcr  = q4_fc_q;
        magr = q4_mag_q;
      end
      default: begin
        fcr  = '0;
        magr = '0;
      end
    endcase
  end

  assign mags            = (magr > 34'h0_8000_0000) ? 34'h0_8000_0000 : magr;
  assign magn            = 34'd0 - mags;
  assign fcs             = (fcr > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : fcr;
  assign tail_res.fc     = fcs;
  assign tail_res.df     = magn[31:0];
  assign tail_res.beyond = q4_side_q.beyond;

  // config, valid pipe, output and skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_COS;
      rc_q       <= '0;
      rcinv_q    <= '0;
      rin_q      <= '0;
      iw_q       <= '0;
      vld_q      <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_MODE:          mode_q  <= mode_e'(cfg_data_i[1:0]);
          REG_CUTOFF_RADIUS: rc_q    <= cfg_data_i[31:0];
          REG_INV_RADIUS:    rcinv_q <= cfg_data_i[31:0];
          REG_INNER_RADIUS:  rin_q   <= cfg_data_i[31:0];
          REG_INV_WIDTH:     iw_q    <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (en) begin
        vld_q <= {vld_q[LAT-2:0], in_valid_i};
      end
      if (!out_vld_q || take) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= en && vld_q[LAT-1];
        end
      end else if (en && vld_q[LAT-1]) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || take) begin
      out_q <= skid_vld_q ? skid_q : tail_res;
    end else if (en && vld_q[LAT-1]) begin
      skid_q <= tail_res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign beyond_cutoff_o = out_q.beyond;

  if (OUT_WIDTH == 32) begin : g_emit_eq
    assign cut_value_o = $signed(out_q.fc);
    assign cut_slope_o = $signed(out_q.df);
  end else if (OUT_WIDTH > 32) begin : g_emit_wide
    assign cut_value_o = $signed({out_q.fc, {(OUT_WIDTH-32){1'b0}}});
    assign cut_slope_o = $signed({out_q.df, {(OUT_WIDTH-32){1'b0}}});
  end else begin : g_emit_narrow
    assign cut_value_o = $signed(out_q.fc[31 -: OUT_WIDTH]);
    assign cut_slope_o = $signed(out_q.df[31 -: OUT_WIDTH]);
  end

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a result while the output register is empty");

  a_tail_parks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[LAT-1] && out_vld_q && out_stall_i) |=> skid_vld_q)
    else $error("tail result dropped while output stalled");

  a_skid_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && out_stall_i && vld_q[LAT-1]))
    else $error("skid filled without a stalled output");

endmodule
